[rtl/brtl_pkg.sv]
// Shared types and constants for the binary trie route lookup block.
// No dependencies; imported by brtl_walk, binary_trie_route_lookup_core and the testbench.
package brtl_pkg;

    // Default node store depth and address width
    localparam int NODES_DEF     = 4096;
    localparam int ADDR_BITS_DEF = 32;

    // Field widths fixed by the word formats
    localparam int ADDR_W  = 32;
    localparam int PLEN_W  = 6;
    localparam int PORT_W  = 8;

    typedef enum logic
    {
        OP_LOOKUP = 1'b0,
        OP_INSERT = 1'b1
    } opcode_t;

    // Command word
    typedef struct packed
    {
        opcode_t             opcode;
        logic [ADDR_W-1:0]   address;
        logic [PLEN_W-1:0]   prefix_length;
        logic [PORT_W-1:0]   route_port;
    } cmd_word_t;

    // Result word
    typedef struct packed
    {
        logic                hit;
        logic [PORT_W-1:0]   port;
        logic                store_full;
    } res_word_t;

    // Walk engine status toward the channel logic
    typedef struct packed
    {
        logic busy;
        logic done;
    } walk_stat_t;

endpackage

[rtl/brtl_walk.sv]
// Trie walk engine: node store, root entry, bump allocator and level sequencer.
// Depends on brtl_pkg for word and status types.
module brtl_walk #(
    parameter int NODES     = brtl_pkg::NODES_DEF,
    parameter int ADDR_BITS = brtl_pkg::ADDR_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  brtl_pkg::cmd_word_t cmd,
    input  logic                res_ready,
    output brtl_pkg::walk_stat_t stat,
    output brtl_pkg::res_word_t result
);
    import brtl_pkg::*;

    localparam int IW = $clog2(NODES);
    localparam int NW = IW + 1;
    localparam int DW = $clog2(ADDR_BITS + 1);

    typedef struct packed
    {
        logic              valid;
        logic [PORT_W-1:0] port;
        logic [IW-1:0]     child1;
        logic [IW-1:0]     child0;
    } entry_t;

    typedef enum logic [2:0]
    {
        ST_IDLE   = 3'b001,
        ST_LOOKUP = 3'b010,
        ST_INSERT = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [ADDR_BITS-1:0]   addr_reg, addr_next;
    logic [DW-1:0]          plen_reg, plen_next;
    logic [DW-1:0]          depth_reg, depth_next;
    logic [IW-1:0]          cur_reg, cur_next;
    logic                   cur_new_reg, cur_new_next;
    logic [PORT_W-1:0]      rport_reg, rport_next;
    logic                   hit_reg, hit_next;
    logic [PORT_W-1:0]      port_reg, port_next;
    logic [NW-1:0]          nfree_reg, nfree_next;
    entry_t                 root_reg, root_next;
    entry_t                 rd_data_reg;

    entry_t                 mem [NODES];

    entry_t                 e_cur;
    entry_t                 wr_data;
    logic                   branch;
    logic [IW-1:0]          nxt;
    logic                   at_plen;
    logic                   at_bottom;
    logic                   full;
    logic                   rd_en;
    logic [IW-1:0]          rd_addr;
    logic                   wr_en;
    logic [IW-1:0]          wr_addr;
    logic                   we_mem;
    logic                   done;
    res_word_t              res_next;

    // Select the current node: root flops, a fresh node, or the store read
    always_comb
    begin
        if (cur_reg == '0)
            e_cur = root_reg;
        else if (cur_new_reg)
            e_cur = '0;
        else
            e_cur = rd_data_reg;
    end

    assign branch    = addr_reg[ADDR_BITS-1];
    assign nxt       = branch ? e_cur.child1 : e_cur.child0;
    assign at_plen   = (depth_reg == plen_reg);
    assign at_bottom = (depth_reg == DW'(ADDR_BITS));
    assign full      = (nfree_reg >= NW'(NODES));

    // Sequence one trie level per cycle; the final level waits for res_ready
    always_comb
    begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        plen_next    = plen_reg;
        depth_next   = depth_reg;
        cur_next     = cur_reg;
        cur_new_next = cur_new_reg;
        rport_next   = rport_reg;
        hit_next     = hit_reg;
        port_next    = port_reg;
        nfree_next   = nfree_reg;
        rd_en        = 1'b0;
        rd_addr      = nxt;
        wr_en        = 1'b0;
        wr_addr      = cur_reg;
        wr_data      = e_cur;
        done         = 1'b0;
        res_next     = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    addr_next    = ADDR_BITS'(cmd.address);
                    if (32'(cmd.prefix_length) > 32'(ADDR_BITS))
                        plen_next = DW'(ADDR_BITS);
                    else
                        plen_next = DW'(cmd.prefix_length);
                    rport_next   = cmd.route_port;
                    depth_next   = '0;
                    cur_next     = '0;
                    cur_new_next = 1'b0;
                    hit_next     = 1'b0;
                    port_next    = '0;
                    state_next   = (cmd.opcode == OP_INSERT) ? ST_INSERT : ST_LOOKUP;
                end
            end

            ST_LOOKUP:
            begin
                // Track the deepest valid node passed
                res_next.hit  = e_cur.valid ? 1'b1 : hit_reg;
                res_next.port = e_cur.valid ? e_cur.port : port_reg;
                if (at_bottom || nxt == '0)
                begin
                    if (res_ready)
                    begin
                        done       = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    hit_next   = res_next.hit;
                    port_next  = res_next.port;
                    rd_en      = 1'b1;
                    cur_next   = nxt;
                    depth_next = depth_reg + DW'(1);
                    addr_next  = addr_reg << 1;
                end
            end

            ST_INSERT:
            begin
                if (at_plen)
                begin
                    // Mark the route node valid
                    if (res_ready)
                    begin
                        wr_en         = 1'b1;
                        wr_data.valid = 1'b1;
                        wr_data.port  = rport_reg;
                        done          = 1'b1;
                        cur_new_next  = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
                else if (nxt != '0)
                begin
                    // Follow an existing child
                    rd_en        = 1'b1;
                    cur_next     = nxt;
                    cur_new_next = 1'b0;
                    depth_next   = depth_reg + DW'(1);
                    addr_next    = addr_reg << 1;
                end
                else if (full)
                begin
                    // Drop the route; flush a fresh node as a pass-through
                    if (res_ready)
                    begin
                        wr_en               = cur_new_reg;
                        res_next.store_full = 1'b1;
                        done                = 1'b1;
                        cur_new_next        = 1'b0;
                        state_next          = ST_IDLE;
                    end
                end
                else
                begin
                    // Allocate a node and link it below the current one
                    wr_en = 1'b1;
                    if (branch)
                        wr_data.child1 = nfree_reg[IW-1:0];
                    else
                        wr_data.child0 = nfree_reg[IW-1:0];
                    cur_next     = nfree_reg[IW-1:0];
                    cur_new_next = 1'b1;
                    nfree_next   = nfree_reg + NW'(1);
                    depth_next   = depth_reg + DW'(1);
                    addr_next    = addr_reg << 1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Route writes at index zero to the root flops
    assign we_mem = wr_en && (wr_addr != '0);

    always_comb
    begin
        root_next = root_reg;
        if (wr_en && wr_addr == '0)
            root_next = wr_data;
    end

    // Control and root state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            depth_reg   <= '0;
            cur_reg     <= '0;
            cur_new_reg <= 1'b0;
            nfree_reg   <= NW'(1);
            root_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            depth_reg   <= depth_next;
            cur_reg     <= cur_next;
            cur_new_reg <= cur_new_next;
            nfree_reg   <= nfree_next;
            root_reg    <= root_next;
        end
    end

    // Walk payload
    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        plen_reg  <= plen_next;
        rport_reg <= rport_next;
        hit_reg   <= hit_next;
        port_reg  <= port_next;
    end

    // Node store: one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we_mem)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign stat.busy = (state_reg != ST_IDLE);
    assign stat.done = done;
    assign result    = res_next;

    // Allocator never runs past the store
    a_nfree_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nfree_reg <= NW'(NODES))
        else $error("node allocator passed the store depth");

    // Store writes only touch allocated nodes
    a_write_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        we_mem |-> (NW'(wr_addr) < nfree_reg))
        else $error("write to an unallocated node");

    // A result is produced only when it can be taken
    a_done_ready: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> res_ready)
        else $error("result produced while output register blocked");

    // Walk depth stays within the address width
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(ADDR_BITS))
        else $error("walk depth beyond address width");

    // Read and write never issue together
    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && wr_en))
        else $error("store read and write in the same cycle");

endmodule

[rtl/binary_trie_route_lookup_core.sv]
// Binary trie longest-prefix-match engine: command and result channels.
// Depends on brtl_pkg and brtl_walk.
//
// Usage:
//   Command words enter on cmd (cmd_valid/cmd_stall). A lookup returns the
//   port of the longest valid prefix covering the address, or a miss; an
//   insert walks the trie, allocating nodes as needed, and stores the port
//   at the given prefix length. Every command yields one result word on res
//   (res_valid/res_stall).
//   Timing: the walk visits one trie level per cycle, bounded by the single
//   node-store port (one read or one write per cycle). The result register
//   loads when the walk finishes its final level, and res shows that
//   register. One command is in flight at a time; cmd_stall stays high
//   while the walk runs, and the next command is accepted from idle, which
//   the walk reenters as the result loads.
//   A new command is accepted while an earlier result still waits in the
//   output register. If res_stall holds that result, the walk pauses at its
//   final level until the register frees up.
//   Reset clears the root entry and sets the allocator to node one; no
//   clearing pass runs, so commands are accepted right after reset.
//   When the store runs out, the insert is dropped with store_full set.
module binary_trie_route_lookup_core #(
    parameter int NODES     = brtl_pkg::NODES_DEF,
    parameter int ADDR_BITS = brtl_pkg::ADDR_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  brtl_pkg::cmd_word_t cmd,
    output logic                res_valid,
    input  logic                res_stall,
    output brtl_pkg::res_word_t res
);
    import brtl_pkg::*;

    walk_stat_t stat;
    res_word_t  walk_res;
    res_word_t  res_reg;
    logic       res_valid_reg;
    logic       res_ready;
    logic       start;

    assign cmd_stall = stat.busy;
    assign start     = cmd_valid && !cmd_stall;
    assign res_ready = !res_valid_reg || !res_stall;

    brtl_walk #(
        .NODES     (NODES),
        .ADDR_BITS (ADDR_BITS)
    ) u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .res_ready (res_ready),
        .stat      (stat),
        .result    (walk_res)
    );

    // Hold the result word until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (stat.done)
            res_valid_reg <= 1'b1;
        else if (!res_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (stat.done)
            res_reg <= walk_res;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

[tb/testbench.sv]
// Self-checking testbench for binary_trie_route_lookup_core: a directed table, then random
// lookups and inserts, each checked against a bit-accurate trie predictor.
// Depends on brtl_pkg and the RTL of binary_trie_route_lookup_core.
module testbench;
    import brtl_pkg::*;

    localparam int NODE_COUNT   = NODES_DEF;
    localparam int WALK_BITS    = ADDR_BITS_DEF;
    localparam int RANDOM_WORDS = 1026;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int TAIL_CYCLES  = 2 * (WALK_BITS + 2);
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 150;

    localparam res_word_t NO_ROUTE = '0;

    // One directed row: command word, whether the answer is typed in, and that answer
    typedef struct packed
    {
        cmd_word_t word;
        bit        typed;
        res_word_t want;
    } dir_row_t;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_stall;
    cmd_word_t cmd;
    logic      res_valid;
    logic      res_stall;
    res_word_t res;

    // Predictor copy of the trie
    bit                trie_valid [NODE_COUNT];
    logic [PORT_W-1:0] trie_port  [NODE_COUNT];
    int unsigned       trie_child [NODE_COUNT][2];
    int unsigned       free_node;

    cmd_word_t stored_prefixes [$];
    res_word_t route_answers   [$];

    int  fault_count;
    int  words_checked;
    int  cycle_count;
    bit  hold_done;

    dir_row_t dir_table [24] = '{
        '{'{OP_LOOKUP, 32'h0000_0000, 6'd0,  8'h00}, 1'b1, NO_ROUTE},
        '{'{OP_LOOKUP, 32'hFFFF_FFFF, 6'd63, 8'hFF}, 1'b1, NO_ROUTE},
        '{'{OP_INSERT, 32'h0000_0000, 6'd0,  8'h11}, 1'b1, NO_ROUTE},
        '{'{OP_LOOKUP, 32'h1234_5678, 6'd0,  8'h00}, 1'b0, NO_ROUTE},
        '{'{OP_INSERT, 32'hFFFF_FFFF, 6'd32, 8'hFF}, 1'b1, NO_ROUTE},
        '{'{OP_LOOKUP, 32'hFFFF_FFFF, 6'd0,  8'h00}, 1'b0, NO_ROUTE},
        '{'{OP_LOOKUP, 32'hFFFF_FFFE, 6'd32, 8'h01}, 1'b0, NO_ROUTE},
        '{'{OP_INSERT, 32'h0000_0000, 6'd32, 8'h00}, 1'b1, NO_ROUTE},
        '{'{OP_LOOKUP, 32'h0000_0000, 6'd0,  8'h00}, 1'b0, NO_ROUTE},
        '{'{OP_INSERT, 32'h0A00_0000, 6'd8,  8'h0A}, 1'b1, NO_ROUTE},
        '{'{OP_INSERT, 32'h0A0B_0000, 6'd16, 8'h0B}, 1'b1, NO_ROUTE},
        '{'{OP_INSERT, 32'h0A0B_0C00, 6'd24, 8'h0C}, 1'b1, NO_ROUTE},
        '{'{OP_LOOKUP, 32'h0A0B_0C0D, 6'd0,  8'h00}, 1'b0, NO_ROUTE},
        '{'{OP_LOOKUP, 32'h0A0B_FFFF, 6'd0,  8'h00}, 1'b0, NO_ROUTE},
        '{'{OP_LOOKUP, 32'h0AFF_0000, 6'd0,  8'h00}, 1'b0, NO_ROUTE},
        '{'{OP_INSERT, 32'h0A0B_0000, 6'd16, 8'h55}, 1'b1, NO_ROUTE},
        '{'{OP_LOOKUP, 32'h0A0B_1234, 6'd0,  8'h00}, 1'b0, NO_ROUTE},
        '{'{OP_INSERT, 32'h8000_0001, 6'd63, 8'h63}, 1'b1, NO_ROUTE},
        '{'{OP_LOOKUP, 32'h8000_0001, 6'd0,  8'h00}, 1'b0, NO_ROUTE},
        '{'{OP_INSERT, 32'h5555_AAAA, 6'd33, 8'hAA}, 1'b1, NO_ROUTE},
        '{'{OP_LOOKUP, 32'h5555_AAAA, 6'd0,  8'h00}, 1'b0, NO_ROUTE},
        '{'{OP_LOOKUP, 32'h5555_AAAB, 6'd0,  8'h00}, 1'b0, NO_ROUTE},
        '{'{OP_INSERT, 32'hC0A8_0000, 6'd0,  8'h77}, 1'b1, NO_ROUTE},
        '{'{OP_LOOKUP, 32'h7FFF_FFFF, 6'd0,  8'h00}, 1'b0, NO_ROUTE}
    };

    binary_trie_route_lookup_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Walk the predictor trie for one command word; inserts update it
    function automatic res_word_t trie_walk_predict(input cmd_word_t w);
        res_word_t   r;
        int unsigned cur;
        int unsigned nxt;
        int          depth;
        int          plen;
        bit          b;
        r   = '0;
        cur = 0;
        if (w.opcode == OP_LOOKUP)
        begin
            for (depth = 0; depth <= WALK_BITS; depth++)
            begin
                if (trie_valid[cur])
                begin
                    r.hit  = 1'b1;
                    r.port = trie_port[cur];
                end
                if (depth == WALK_BITS)
                    break;
                cur = trie_child[cur][w.address[WALK_BITS-1-depth]];
                if (cur == 0)
                    break;
            end
            return r;
        end
        plen = (w.prefix_length > WALK_BITS) ? WALK_BITS : int'(w.prefix_length);
        for (depth = 0; depth < plen; depth++)
        begin
            b   = w.address[WALK_BITS-1-depth];
            nxt = trie_child[cur][b];
            if (nxt == 0)
            begin
                // Out of nodes: keep the pass-through nodes, drop the route
                if (free_node >= NODE_COUNT)
                begin
                    r.store_full = 1'b1;
                    return r;
                end
                nxt = free_node;
                free_node++;
                trie_valid[nxt]    = 1'b0;
                trie_port[nxt]     = '0;
                trie_child[nxt][0] = 0;
                trie_child[nxt][1] = 0;
                trie_child[cur][b] = nxt;
            end
            cur = nxt;
        end
        trie_valid[cur] = 1'b1;
        trie_port[cur]  = w.route_port;
        stored_prefixes.push_back(w);
        return r;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return 0;
        else if (pick < 85)
            return $urandom_range(1, 3);
        else if (pick < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Offer one command word after a gap; predict it once accepted
    task automatic offer_word(input cmd_word_t w, input int gap, input bit typed,
                              input res_word_t want);
        res_word_t pred;
        if (gap > 0)
        begin
            @(negedge clk);
            cmd_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd       <= w;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        pred = trie_walk_predict(w);
        route_answers.push_back(typed ? want : pred);
    endtask

    // Drop valid and hold until every outstanding answer has come back
    task automatic drain_answers();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (route_answers.size() != 0)
            @(posedge clk);
    endtask

    // Compare each accepted result word with the oldest outstanding answer
    always @(posedge clk)
    begin
        res_word_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            words_checked++;
            if (route_answers.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result word: hit=%0d port=%02h store_full=%0d",
                             res.hit, res.port, res.store_full);
            end
            else
            begin
                want = route_answers.pop_front();
                if (res.hit !== want.hit || res.port !== want.port
                    || res.store_full !== want.store_full)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                    begin
                        $display("mismatch at word %0d: expected hit=%0d port=%02h full=%0d",
                                 words_checked, want.hit, want.port, want.store_full);
                        $display("    got hit=%0d port=%02h full=%0d",
                                 res.hit, res.port, res.store_full);
                    end
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off to back the block up
    initial
    begin
        int run;
        res_stall = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!hold_done && words_checked >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                @(negedge clk);
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            run = idle_len();
            if (run > 0)
            begin
                @(negedge clk);
                res_stall <= 1'b1;
                repeat (run - 1) @(negedge clk);
            end
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
            @(negedge clk);
            res_stall <= 1'b0;
            repeat (run - 1) @(negedge clk);
        end
    end

    // Cycle counter: end the run if the block hangs
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL binary_trie_route_lookup_core");
        $finish;
    end

    // Sender: reset, directed table, then random traffic
    initial
    begin
        cmd_word_t   w;
        cmd_word_t   k;
        logic [31:0] keep_mask;
        int          keep;
        int          pick;
        int          len_pick;
        int          i;
        clk           = 1'b0;
        rst_n         = 1'b0;
        cmd_valid     = 1'b0;
        cmd           = '0;
        fault_count   = 0;
        words_checked = 0;
        for (i = 0; i < NODE_COUNT; i++)
        begin
            trie_valid[i]    = 1'b0;
            trie_port[i]     = '0;
            trie_child[i][0] = 0;
            trie_child[i][1] = 0;
        end
        free_node = 1;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        for (i = 0; i < $size(dir_table); i++)
            offer_word(dir_table[i].word, idle_len(), dir_table[i].typed, dir_table[i].want);
        drain_answers();

        // Random part: lookups near stored prefixes, fully random lookups, new and repeated inserts
        for (i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == RANDOM_WORDS / 2)
                drain_answers();
            w.opcode        = OP_LOOKUP;
            w.address       = ADDR_W'($urandom);
            w.prefix_length = PLEN_W'($urandom);
            w.route_port    = PORT_W'($urandom);
            k = (stored_prefixes.size() > 0)
                ? stored_prefixes[$urandom_range(0, stored_prefixes.size() - 1)] : w;
            keep      = (k.prefix_length > WALK_BITS) ? WALK_BITS : int'(k.prefix_length);
            keep_mask = 32'(~(64'hFFFF_FFFF >> keep));
            pick      = $urandom_range(0, 99);
            if (pick < 40)
            begin
                if ($urandom_range(0, 3) != 0)
                    w.address = (k.address & keep_mask) | (w.address & ~keep_mask);
            end
            else if (pick < 50)
            begin
                // fully random lookup
            end
            else if (pick < 60)
            begin
                w.opcode        = OP_INSERT;
                w.address       = k.address;
                w.prefix_length = k.prefix_length;
            end
            else
            begin
                w.opcode = OP_INSERT;
                len_pick = $urandom_range(0, 99);
                if (len_pick < 20)
                    w.prefix_length = PLEN_W'($urandom_range(0, 23));
                else if (len_pick < 85)
                    w.prefix_length = PLEN_W'($urandom_range(24, 32));
                else
                    w.prefix_length = PLEN_W'($urandom_range(33, 63));
                if ($urandom_range(0, 1) == 0)
                    w.address = (k.address & keep_mask) | (w.address & ~keep_mask);
            end
            offer_word(w, idle_len(), 1'b0, NO_ROUTE);
        end
        drain_answers();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fault_count == 0 && route_answers.size() == 0)
            $display("PASS binary_trie_route_lookup_core");
        else
            $display("FAIL binary_trie_route_lookup_core");
        $finish;
    end

endmodule
